FILE: sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Sequencer states, status and command codes, register indexes, divider
// request and response, and compensation constants.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int CFG_DATA_W = 64;
	localparam int DIV_W      = 48;
	localparam int DIV_SHORT_STEPS = 32;
	localparam int DIV_LONG_STEPS  = 48;

	localparam logic [1:0] CFG_CAL_A = 2'd0;
	localparam logic [1:0] CFG_CAL_B = 2'd1;
	localparam logic [1:0] CFG_CAL_C = 2'd2;
	localparam logic [1:0] CFG_SEA   = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_TEMP  = 2'd1;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	localparam logic [31:0] TEMP_B6_OFFSET = 32'd4000;
	localparam logic [31:0] P_COEF_C1      = 32'd3038;
	localparam logic [31:0] P_COEF_C2      = 32'hFFFF_E343;
	localparam logic [31:0] P_CORR_OFFSET  = 32'd3791;
	localparam logic [32:0] ALT_SCALE      = 33'd8434;
	localparam logic [16:0] P0_DEFAULT     = 17'd101325;
	localparam logic [31:0] B7_SCALE       = 32'd50000;
	localparam logic [31:0] B4_OFFSET      = 32'd32768;
	localparam logic [17:0] PRESS_MAX      = 18'd262143;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TMUL,
		ST_TX1,
		ST_TDIV,
		ST_TFIN,
		ST_PM1,
		ST_PM2,
		ST_PM3,
		ST_PM4,
		ST_PM5,
		ST_PM6,
		ST_PM7,
		ST_PB4,
		ST_PDIV,
		ST_PM8,
		ST_PM9,
		ST_PM10,
		ST_PM11,
		ST_PSTART,
		ST_PADIV,
		ST_PFIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              start;
		logic              long_op;
		logic [DIV_W-1:0]  dividend;
		logic [31:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quotient;
	} div_rsp_t;

	function automatic logic [31:0] asr32(logic [31:0] v, int n);
		asr32 = 32'($signed(v) >>> n);
	endfunction

endpackage

FILE: sv/bsc_in_if.sv
// ----------------------------------------------------------------------------
// bsc_in_if: raw reading channel
// Valid/ready channel carrying one raw sensor reading per transaction.
// ----------------------------------------------------------------------------
interface bsc_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [23:0] raw_reading;
	logic [1:0]  oversampling;

	modport source (output valid, cmd, raw_reading, oversampling, input ready);
	modport sink (input valid, cmd, raw_reading, oversampling, output ready);
endinterface

FILE: sv/bsc_out_if.sv
// ----------------------------------------------------------------------------
// bsc_out_if: compensated result channel
// Valid/ready channel carrying one compensated result per transaction.
// ----------------------------------------------------------------------------
interface bsc_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [1:0]         status;
	logic signed [15:0] temperature_dc;
	logic [17:0]        pressure_pa;
	logic signed [15:0] altitude_m;

	modport source (output valid, kind, status, temperature_dc, pressure_pa, altitude_m,
		input ready);
	modport sink (input valid, kind, status, temperature_dc, pressure_pa, altitude_m,
		output ready);
endinterface

FILE: sv/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div: iterative unsigned divider
// Restoring divider, one quotient bit per cycle, 32 or 48 steps.
// ----------------------------------------------------------------------------
module bsc_div
	import bsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic             long_q;
	logic [5:0]       cnt_q;
	logic [DIV_W-1:0] dq_q;
	logic [31:0]      rem_q;
	logic [31:0]      den_q;
	logic [32:0]      trial;
	logic [32:0]      diff;
	logic             fit;

	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fit   = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.long_op ? 6'(DIV_LONG_STEPS - 1) : 6'(DIV_SHORT_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			long_q <= req.long_op;
			dq_q   <= req.long_op ? req.dividend : {req.dividend[31:0], 16'b0};
			rem_q  <= '0;
			den_q  <= req.divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIV_W-2:0], fit};
			rem_q <= fit ? diff[31:0] : trial[31:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = long_q ? dq_q : {16'b0, dq_q[31:0]};

endmodule

FILE: sv/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: temperature and pressure compensation
// Sequencer around one shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  in_ch    | sink      | cmd, raw_reading, oversampling
//  out_ch   | source    | kind, status, temperature_dc, pressure_pa, altitude_m
//  cfg      | write     | cfg_we, cfg_index, cfg_data, no read-back
//
// A temperature transaction runs one multiply and a 32-step divide, a pressure
// transaction its multiplies in sequence, a 32-step and a 48-step divide. One
// transaction is in work at a time; in_ch.ready is high in idle only. A result
// waits in the output register while the next transaction is accepted. Reset
// clears the control state, configuration and stored B5 term.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation
	import bsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bsc_in_if.sink                in_ch,
	bsc_out_if.source             out_ch
);

	state_t state_q, state_d;

	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [31:0] cal_c_q;
	logic [16:0] sea_q;

	logic [31:0] b5_q;
	logic        b5_valid_q;

	logic        cmd_q;
	logic [23:0] raw_q;
	logic [1:0]  oss_q;

	logic signed [47:0] prod_q;
	logic [31:0] x_q, sq_q, b3_q, b4_q, b7_q, p_q;
	logic        neg_q;

	logic [1:0]         res_status_q;
	logic signed [15:0] res_t_q;
	logic [17:0]        res_p_q;
	logic signed [15:0] res_a_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic [1:0]         out_status_q;
	logic signed [15:0] out_t_q;
	logic [17:0]        out_p_q;
	logic signed [15:0] out_a_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic signed [32:0] mul_a, mul_b;
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] prod32, b6, sq_c, x3_c, b3_c, x3b_c, p_div_c, p_fin_c;
	logic [31:0] x1t, den, num, num_abs, den_abs, up, x2t, b5_c, t_c;
	logic [16:0] p0_c;
	logic signed [32:0] diff33;
	logic [47:0] alt_c, prod_abs;
	logic        out_free, accept;

	function automatic logic signed [32:0] sx(logic [31:0] v);
		sx = $signed({v[31], v});
	endfunction

	function automatic logic signed [15:0] sat16_32(logic [31:0] v);
		if ($signed(v) < -32'sd32768)
			sat16_32 = -16'sd32768;
		else if ($signed(v) > 32'sd32767)
			sat16_32 = 16'sd32767;
		else
			sat16_32 = $signed(v[15:0]);
	endfunction

	function automatic logic signed [15:0] sat16_48(logic [47:0] v);
		if ($signed(v) < -48'sd32768)
			sat16_48 = -16'sd32768;
		else if ($signed(v) > 48'sd32767)
			sat16_48 = 16'sd32767;
		else
			sat16_48 = $signed(v[15:0]);
	endfunction

	assign ac1 = 32'($signed(cal_a_q[63:48]));
	assign ac2 = 32'($signed(cal_a_q[47:32]));
	assign ac3 = 32'($signed(cal_a_q[31:16]));
	assign ac4 = {16'b0, cal_a_q[15:0]};
	assign ac5 = {16'b0, cal_b_q[63:48]};
	assign ac6 = {16'b0, cal_b_q[47:32]};
	assign b1  = 32'($signed(cal_b_q[31:16]));
	assign b2  = 32'($signed(cal_b_q[15:0]));
	assign mc  = 32'($signed(cal_c_q[31:16]));
	assign md  = 32'($signed(cal_c_q[15:0]));

	assign prod32  = prod_q[31:0];
	assign b6      = b5_q - TEMP_B6_OFFSET;
	assign sq_c    = asr32(prod32, 12);
	assign x3_c    = x_q + asr32(prod32, 11);
	assign b3_c    = asr32((((ac1 << 2) + x3_c) << oss_q) + 32'd2, 2);
	assign x3b_c   = asr32(x_q + asr32(prod32, 16) + 32'd2, 2);
	assign p_div_c = b7_q[31] ? {div_rsp.quotient[30:0], 1'b0} : div_rsp.quotient[31:0];
	assign p_fin_c = p_q + asr32(x_q + asr32(prod32, 16) + P_CORR_OFFSET, 4);
	assign p0_c    = (sea_q == '0) ? P0_DEFAULT : sea_q;
	assign diff33  = $signed({16'b0, p0_c}) - sx(p_fin_c);
	assign up      = {8'b0, raw_q} >> (4'd8 - {2'b0, oss_q});

	assign x1t     = asr32(prod32, 15);
	assign den     = x1t + md;
	assign num     = mc << 11;
	assign num_abs = num[31] ? (32'd0 - num) : num;
	assign den_abs = den[31] ? (32'd0 - den) : den;
	assign x2t     = neg_q ? (32'd0 - div_rsp.quotient[31:0]) : div_rsp.quotient[31:0];
	assign b5_c    = x_q + x2t;
	assign t_c     = asr32(b5_c + 32'd8, 4);
	assign alt_c   = neg_q ? (48'd0 - div_rsp.quotient) : div_rsp.quotient;
	assign prod_abs = prod_q[47] ? (48'd0 - prod_q) : prod_q;

	assign out_free = !out_valid_q || out_ch.ready;
	assign accept   = in_ch.valid && in_ch.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.cmd == CMD_TEMP)
						state_d = ST_TMUL;
					else if (!b5_valid_q)
						state_d = ST_DONE;
					else
						state_d = ST_PM1;
				end
			end
			ST_TMUL:   state_d = ST_TX1;
			ST_TX1:    state_d = (den == '0) ? ST_DONE : ST_TDIV;
			ST_TDIV:   state_d = div_rsp.done ? ST_TFIN : ST_TDIV;
			ST_TFIN:   state_d = ST_DONE;
			ST_PM1:    state_d = ST_PM2;
			ST_PM2:    state_d = ST_PM3;
			ST_PM3:    state_d = ST_PM4;
			ST_PM4:    state_d = ST_PM5;
			ST_PM5:    state_d = ST_PM6;
			ST_PM6:    state_d = ST_PM7;
			ST_PM7:    state_d = ST_PB4;
			ST_PB4:    state_d = (b4_q == '0) ? ST_DONE : ST_PDIV;
			ST_PDIV:   state_d = div_rsp.done ? ST_PM8 : ST_PDIV;
			ST_PM8:    state_d = ST_PM9;
			ST_PM9:    state_d = ST_PM10;
			ST_PM10:   state_d = ST_PM11;
			ST_PM11:   state_d = ST_PSTART;
			ST_PSTART: state_d = ST_PADIV;
			ST_PADIV:  state_d = div_rsp.done ? ST_PFIN : ST_PADIV;
			ST_PFIN:   state_d = ST_DONE;
			ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.long_op  = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		in_ch.ready      = (state_q == ST_IDLE);
		case (state_q)
			ST_TMUL: begin
				mul_a = sx({16'b0, raw_q[15:0]} - ac6);
				mul_b = sx(ac5);
			end
			ST_TX1: begin
				div_req.start    = (den != '0);
				div_req.dividend = {16'b0, num_abs};
				div_req.divisor  = den_abs;
			end
			ST_PM1: begin
				mul_a = sx(b6);
				mul_b = sx(b6);
			end
			ST_PM2: begin
				mul_a = sx(b2);
				mul_b = sx(sq_c);
			end
			ST_PM3: begin
				mul_a = sx(ac2);
				mul_b = sx(b6);
			end
			ST_PM4: begin
				mul_a = sx(ac3);
				mul_b = sx(b6);
			end
			ST_PM5: begin
				mul_a = sx(b1);
				mul_b = sx(sq_q);
			end
			ST_PM6: begin
				mul_a = sx(ac4);
				mul_b = sx(x3b_c + B4_OFFSET);
			end
			ST_PM7: begin
				mul_a = sx(up - b3_q);
				mul_b = sx(B7_SCALE >> oss_q);
			end
			ST_PB4: begin
				div_req.start    = (b4_q != '0);
				div_req.dividend = {16'b0, (prod32[31] ? prod32 : {prod32[30:0], 1'b0})};
				div_req.divisor  = b4_q;
			end
			ST_PM8: begin
				mul_a = sx(asr32(p_div_c, 8));
				mul_b = sx(asr32(p_div_c, 8));
			end
			ST_PM9: begin
				mul_a = sx(prod32);
				mul_b = sx(P_COEF_C1);
			end
			ST_PM10: begin
				mul_a = sx(P_COEF_C2);
				mul_b = sx(p_q);
			end
			ST_PM11: begin
				mul_a = diff33;
				mul_b = $signed(ALT_SCALE);
			end
			ST_PSTART: begin
				div_req.start    = 1'b1;
				div_req.long_op  = 1'b1;
				div_req.dividend = prod_abs;
				div_req.divisor  = {15'b0, p0_c};
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cal_a_q     <= '0;
			cal_b_q     <= '0;
			cal_c_q     <= '0;
			sea_q       <= '0;
			b5_q        <= '0;
			b5_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAL_A: cal_a_q <= cfg_data;
					CFG_CAL_B: cal_b_q <= cfg_data;
					CFG_CAL_C: cal_c_q <= cfg_data[31:0];
					CFG_SEA:   sea_q   <= cfg_data[16:0];
					default:   sea_q   <= sea_q;
				endcase
			end
			if (state_q == ST_TFIN) begin
				b5_q       <= b5_c;
				b5_valid_q <= 1'b1;
			end
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 48'(mul_a * mul_b);
		if (accept) begin
			cmd_q        <= in_ch.cmd;
			raw_q        <= in_ch.raw_reading;
			oss_q        <= in_ch.oversampling;
			res_status_q <= (in_ch.cmd == CMD_PRESS) ? STATUS_NO_TEMP : STATUS_OK;
			res_t_q      <= '0;
			res_p_q      <= '0;
			res_a_q      <= '0;
		end
		case (state_q)
			ST_TX1: begin
				x_q   <= x1t;
				neg_q <= num[31] ^ den[31];
				if (den == '0)
					res_status_q <= STATUS_DIV_ZERO;
			end
			ST_TFIN: begin
				res_t_q <= sat16_32(t_c);
			end
			ST_PM2: sq_q <= sq_c;
			ST_PM3: x_q  <= asr32(prod32, 11);
			ST_PM4: b3_q <= b3_c;
			ST_PM5: x_q  <= asr32(prod32, 13);
			ST_PM7: b4_q <= prod32 >> 15;
			ST_PB4: begin
				b7_q <= prod32;
				if (b4_q == '0)
					res_status_q <= STATUS_DIV_ZERO;
			end
			ST_PM8:  p_q <= p_div_c;
			ST_PM10: x_q <= asr32(prod32, 16);
			ST_PM11: p_q <= p_fin_c;
			ST_PSTART: neg_q <= prod_q[47];
			ST_PFIN: begin
				res_status_q <= STATUS_OK;
				res_a_q      <= sat16_48(alt_c);
				if ($signed(p_q) < 32'sd0)
					res_p_q <= '0;
				else if (p_q > {14'b0, PRESS_MAX})
					res_p_q <= PRESS_MAX;
				else
					res_p_q <= p_q[17:0];
			end
			default: begin
				x_q <= x_q;
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_kind_q   <= cmd_q;
			out_status_q <= res_status_q;
			out_t_q      <= res_t_q;
			out_p_q      <= res_p_q;
			out_a_q      <= res_a_q;
		end
	end

	bsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_ch.valid          = out_valid_q;
	assign out_ch.kind           = out_kind_q;
	assign out_ch.status         = out_status_q;
	assign out_ch.temperature_dc = out_t_q;
	assign out_ch.pressure_pa    = out_p_q;
	assign out_ch.altitude_m     = out_a_q;

endmodule

FILE: sim/bsc_comp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_comp_checker: compensation result checker
// Watches the configuration port and both channels, predicts every result
// from the calibration shadow and the stored B5 term, and compares each
// output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module bsc_comp_checker
	import bsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	bsc_in_if                     in_ch,
	bsc_out_if                    out_ch,
	output int                    err_count,
	output int                    pending
);

	typedef struct packed {
		logic               kind;
		logic [1:0]         status;
		logic signed [15:0] temperature_dc;
		logic [17:0]        pressure_pa;
		logic signed [15:0] altitude_m;
	} comp_t;

	logic [63:0] cal_a;
	logic [63:0] cal_b;
	logic [31:0] cal_c;
	logic [16:0] sea_pa;
	logic [31:0] b5_term;
	logic        b5_valid;
	comp_t       comp_queue[$];

	function automatic logic [31:0] sra(logic [31:0] v, int n);
		sra = 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] sx16(logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	function automatic comp_t compensate(logic cmd, logic [23:0] raw, logic [1:0] oss);
		comp_t r;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] ut, x1, x2, x3, num, den, b5, t, up, b6, sq, b3, b4, b7, p;
		logic signed [63:0] q;
		int ps, tt;
		longint p0, alt;
		ac1 = sx16(cal_a[63:48]);
		ac2 = sx16(cal_a[47:32]);
		ac3 = sx16(cal_a[31:16]);
		ac4 = {16'd0, cal_a[15:0]};
		ac5 = {16'd0, cal_b[63:48]};
		ac6 = {16'd0, cal_b[47:32]};
		b1 = sx16(cal_b[31:16]);
		b2 = sx16(cal_b[15:0]);
		mc = sx16(cal_c[31:16]);
		md = sx16(cal_c[15:0]);
		r = '0;
		r.kind = cmd;
		if (cmd == CMD_TEMP) begin
			ut = {16'd0, raw[15:0]};
			x1 = sra((ut - ac6) * ac5, 15);
			num = mc << 11;
			den = x1 + md;
			if (den == 32'd0) begin
				r.status = STATUS_DIV_ZERO;
			end else begin
				q = $signed({{32{num[31]}}, num}) / $signed({{32{den[31]}}, den});
				x2 = q[31:0];
				b5 = x1 + x2;
				t = sra(b5 + 32'd8, 4);
				tt = $signed(t);
				r.temperature_dc = tt > 32767 ? 16'sd32767 :
					(tt < -32768 ? -16'sd32768 : 16'(tt));
				b5_term = b5;
				b5_valid = 1'b1;
			end
		end else if (!b5_valid) begin
			r.status = STATUS_NO_TEMP;
		end else begin
			up = {8'd0, raw} >> (8 - oss);
			b6 = b5_term - 32'd4000;
			sq = sra(b6 * b6, 12);
			x1 = sra(b2 * sq, 11);
			x2 = sra(ac2 * b6, 11);
			x3 = x1 + x2;
			b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
			x1 = sra(ac3 * b6, 13);
			x2 = sra(b1 * sq, 16);
			x3 = sra(x1 + x2 + 32'd2, 2);
			b4 = (ac4 * (x3 + 32'd32768)) >> 15;
			b7 = (up - b3) * (32'd50000 >> oss);
			if (b4 == 32'd0) begin
				r.status = STATUS_DIV_ZERO;
			end else begin
				if (b7 < 32'h8000_0000)
					p = (b7 << 1) / b4;
				else
					p = (b7 / b4) << 1;
				x1 = sra(p, 8) * sra(p, 8);
				x1 = sra(x1 * 32'd3038, 16);
				x2 = sra((32'd0 - 32'd7357) * p, 16);
				p = p + sra(x1 + x2 + 32'd3791, 4);
				ps = $signed(p);
				p0 = (sea_pa != 17'd0) ? longint'(sea_pa) : 64'sd101325;
				alt = ((p0 - longint'(ps)) * 64'sd8434) / p0;
				r.pressure_pa = ps < 0 ? 18'd0 : (ps > 262143 ? 18'd262143 : 18'(ps));
				r.altitude_m = alt > 32767 ? 16'sd32767 :
					(alt < -32768 ? -16'sd32768 : 16'(alt));
			end
		end
		return r;
	endfunction

	assign pending = comp_queue.size();

	always @(posedge clk or negedge arst_n) begin
		comp_t got, want;
		if (!arst_n) begin
			cal_a = '0;
			cal_b = '0;
			cal_c = '0;
			sea_pa = '0;
			b5_term = '0;
			b5_valid = 1'b0;
			err_count = 0;
			comp_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAL_A: cal_a = cfg_data;
					CFG_CAL_B: cal_b = cfg_data;
					CFG_CAL_C: cal_c = cfg_data[31:0];
					CFG_SEA:   sea_pa = cfg_data[16:0];
					default:   sea_pa = sea_pa;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.kind, out_ch.status, out_ch.temperature_dc,
					out_ch.pressure_pa, out_ch.altitude_m};
				if (comp_queue.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result transaction: %p", got);
				end else begin
					want = comp_queue.pop_front();
					if (got !== want) begin
						err_count++;
						if (err_count <= 10)
							$display("result mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				comp_queue.push_back(compensate(in_ch.cmd, in_ch.raw_reading,
					in_ch.oversampling));
		end
	end

endmodule

FILE: sim/barometric_sensor_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_tb: compensation block testbench
// Writes several calibration sets, drives directed and random raw readings
// with random idle bursts on both channels, and reports the checker verdict.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_tb;
	import bsc_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [63:0] CAL_A_TYP = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
	localparam logic [63:0] CAL_B_TYP = {16'd32757, 16'd23153, 16'd6190, 16'd4};
	localparam logic [31:0] CAL_C_TYP = {16'hDDE9, 16'd2868};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  calm;
	int                    stall_left;
	int                    cycles;
	int                    err_count;
	int                    pending;

	bsc_in_if  in_ch();
	bsc_out_if out_ch();

	barometric_sensor_compensation u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	bsc_comp_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.err_count (err_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (calm) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic load_cal(logic [63:0] a, logic [63:0] b, logic [31:0] c, logic [16:0] sea);
		write_reg(CFG_CAL_A, a);
		write_reg(CFG_CAL_B, b);
		write_reg(CFG_CAL_C, {32'd0, c});
		write_reg(CFG_SEA, {47'd0, sea});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_reading(logic cmd, logic [23:0] raw, logic [1:0] oss);
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.raw_reading <= raw;
		in_ch.oversampling <= oss;
		do @(posedge clk); while (!in_ch.ready);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_readings(int count);
		logic [1:0]  oss;
		logic [23:0] raw;
		logic [15:0] ut;
		logic [23:0] up;
		repeat (count) begin
			oss = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 3) == 0) begin
					ut = 16'(27898 + $urandom_range(0, 8000) - 4000);
					send_reading(CMD_TEMP, {8'($urandom), ut}, oss);
				end else begin
					up = 24'(23843 + $urandom_range(0, 6000) - 3000);
					raw = (up << (8 - oss)) | 24'($urandom_range(0, 255) >> oss);
					send_reading(CMD_PRESS, raw, oss);
				end
			end else begin
				send_reading(1'($urandom), 24'($urandom), oss);
			end
		end
	endtask

	initial begin
		calm = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_TEMP;
		in_ch.raw_reading = '0;
		in_ch.oversampling = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_reading(CMD_PRESS, 24'h5D2300, 2'd0);
		send_reading(CMD_TEMP, 24'h006CFA, 2'd0);
		send_reading(CMD_PRESS, 24'hFFFFFF, 2'd3);
		drain();

		load_cal(CAL_A_TYP, CAL_B_TYP, CAL_C_TYP, 17'd0);
		send_reading(CMD_TEMP, 24'h006CFA, 2'd0);
		for (int o = 0; o < 4; o++)
			send_reading(CMD_PRESS, 24'(23843) << (8 - o), 2'(o));
		send_reading(CMD_PRESS, 24'h000000, 2'd0);
		send_reading(CMD_PRESS, 24'hFFFFFF, 2'd3);
		send_reading(CMD_TEMP, 24'hFF0000, 2'd3);
		send_reading(CMD_PRESS, 24'hFFFFFF, 2'd0);
		send_reading(CMD_TEMP, 24'h00FFFF, 2'd0);
		send_reading(CMD_PRESS, 24'h000000, 2'd3);
		drain();

		load_cal({CAL_A_TYP[63:16], 16'd0}, CAL_B_TYP, CAL_C_TYP, 17'd131071);
		send_reading(CMD_TEMP, 24'h006CFA, 2'd0);
		send_reading(CMD_PRESS, 24'h5D2300, 2'd0);
		send_reading(CMD_PRESS, 24'hFFFFFF, 2'd1);
		drain();

		load_cal({64{1'b1}}, {64{1'b1}}, {32{1'b1}}, 17'd1);
		send_reading(CMD_TEMP, 24'h000000, 2'd0);
		send_reading(CMD_PRESS, 24'h800000, 2'd2);
		random_readings(100);
		drain();

		load_cal(CAL_A_TYP, CAL_B_TYP, CAL_C_TYP, 17'd0);
		random_readings(250);
		drain();

		load_cal({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 17'($urandom));
		random_readings(150);
		drain();

		load_cal(CAL_A_TYP ^ {16'($urandom_range(0, 255)), 48'd0}, CAL_B_TYP,
			CAL_C_TYP, 17'd100000 + 17'($urandom_range(0, 3000)));
		random_readings(250);
		drain();

		load_cal(CAL_A_TYP, CAL_B_TYP, CAL_C_TYP, 17'd95000);
		calm <= 1'b1;
		random_readings(250);
		drain();

		if (err_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
